// ===== src/balanced_ternary_length_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the balanced ternary length decoder
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef BALANCED_TERNARY_LENGTH_DECODER_ASSERT_SVH
`define BALANCED_TERNARY_LENGTH_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTLD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/btld_pkg.sv =====
// ---------------------------------------------------------------------------
// btld_pkg
// Widths, status codes, the power-of-27 table and the result record shared
// by the decoder modules and channel interfaces.
// ---------------------------------------------------------------------------
`default_nettype none

package btld_pkg;

  localparam int DIGIT_W  = 5;
  localparam int VALUE_W  = 61;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;
  localparam int SUM_W    = 62;
  localparam int POW_W    = 59;
  localparam int PROD_W   = 64;

  localparam int MAX_DIGITS = 13;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EOF      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NEGATIVE = 2'd3;

  localparam logic signed [DIGIT_W-1:0] COUNT_MAX = DIGIT_W'(MAX_DIGITS);
  localparam logic signed [DIGIT_W-1:0] DIGIT_HI  = 5'sd13;
  localparam logic signed [DIGIT_W-1:0] DIGIT_LO  = -5'sd13;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 61'd2026277576509488133;

  typedef struct packed {
    logic                emit;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
  } result_t;

  // Weight of digit position idx; positions past the table weigh nothing.
  function automatic logic signed [POW_W-1:0] pow27(input logic [COUNT_W-1:0] idx);
    logic signed [POW_W-1:0] w;
    case (idx)
      4'd0:    w = 59'sd1;
      4'd1:    w = 59'sd27;
      4'd2:    w = 59'sd729;
      4'd3:    w = 59'sd19683;
      4'd4:    w = 59'sd531441;
      4'd5:    w = 59'sd14348907;
      4'd6:    w = 59'sd387420489;
      4'd7:    w = 59'sd10460353203;
      4'd8:    w = 59'sd282429536481;
      4'd9:    w = 59'sd7625597484987;
      4'd10:   w = 59'sd205891132094649;
      4'd11:   w = 59'sd5559060566555523;
      4'd12:   w = 59'sd150094635296999121;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/btld_in_if.sv =====
// ---------------------------------------------------------------------------
// btld_in_if
// Tryte channel: one signed balanced base-27 digit and a buffer end flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface btld_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [btld_pkg::DIGIT_W-1:0] digit;
  logic                                buffer_end;

  modport source (output valid, output digit, output buffer_end, input ready);
  modport sink   (input valid, input digit, input buffer_end, output ready);
endinterface

`default_nettype wire

// ===== src/btld_out_if.sv =====
// ---------------------------------------------------------------------------
// btld_out_if
// Result channel: decoded value and status of one field.
// ---------------------------------------------------------------------------
`default_nettype none

interface btld_out_if;
  logic                          valid;
  logic                          ready;
  logic [btld_pkg::VALUE_W-1:0]  value;
  logic [btld_pkg::STATUS_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== src/balanced_ternary_length_decoder.sv =====
// ---------------------------------------------------------------------------
// balanced_ternary_length_decoder
// Decodes length-prefixed balanced base-27 integers from a tryte stream.
// ---------------------------------------------------------------------------
// Usage:
//   trytes  (sink)   one tryte per item: digit (-16..15 signed) and
//                    buffer_end, set on the last tryte of the buffer.
//   results (source) one item per field: value (61 bits) and status
//                    (ok, end of buffer, invalid count, negative value).
//   The first tryte of a field is its digit count, the following trytes are
//   the digits, least significant first. A tryte that opens a field with a
//   count of 1 to 13, or carries an inner digit, gives no result item unless
//   it has buffer_end set. Throughput: one tryte per cycle while no result
//   waits on a stalled results port. A result item reaches the results port
//   through the input register, then the multiply-add into the result
//   register. The path is one 5 x 59 bit multiply by a tabled power of 27
//   and one 62 bit add.
//   Reset (rst, synchronous): drops any tryte in flight and any waiting
//   result, and returns to expecting a count tryte.
//   Stall: a result waits in the output register while results.ready is low;
//   trytes that close no field keep flowing, and intake stops only when a
//   second result is ready with the output register still full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "balanced_ternary_length_decoder_assert.svh"

module balanced_ternary_length_decoder (
  input  wire logic clk,
  input  wire logic rst,
  btld_in_if.sink   trytes,
  btld_out_if.source results
);
  import btld_pkg::*;

  // Input register.
  logic                      s1_valid;
  logic signed [DIGIT_W-1:0] s1_digit;
  logic                      s1_end;

  // Output register.
  logic                      out_valid;
  logic [VALUE_W-1:0]        out_value;
  logic [STATUS_W-1:0]       out_status;

  result_t res;
  logic    advance;
  logic    step;

  // The held tryte may go ahead unless it closes a field while the output
  // register is full and not being drained.
  assign advance = !res.emit || !out_valid || results.ready;
  assign step    = s1_valid && advance;

  assign trytes.ready = !s1_valid || advance;

  btld_field u_field (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .digit      (s1_digit),
    .buffer_end (s1_end),
    .res        (res)
  );

  // Load the input register on accept, drop it once stepped.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (trytes.valid && trytes.ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (trytes.valid && trytes.ready) begin
      s1_digit <= trytes.digit;
      s1_end   <= trytes.buffer_end;
    end
  end

  // Clear on take, then load a fresh result over it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_value  <= res.value;
      out_status <= res.status;
    end
  end

  assign results.valid  = out_valid;
  assign results.value  = out_value;
  assign results.status = out_status;

  `BTLD_ASSERT_NOW(a_error_value_zero, results.valid && results.status != ST_OK,
    results.value == '0, "error result carries a nonzero value")
  `BTLD_ASSERT_NOW(a_value_in_range, results.valid && results.status == ST_OK,
    results.value <= VALUE_MAX, "decoded value above the 13-digit maximum")
  `BTLD_ASSERT_NEXT(a_result_loaded, step && res.emit,
    out_valid && out_status == $past(res.status), "closed field lost its result")

endmodule

`default_nettype wire

// ===== src/btld_field.sv =====
// ---------------------------------------------------------------------------
// btld_field
// Field state and per-tryte step: count parsing, digit weighting and the
// running signed sum, with the result of the step when a field closes.
// ---------------------------------------------------------------------------
`default_nettype none

`include "balanced_ternary_length_decoder_assert.svh"

module btld_field (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                step,
  input  wire logic signed [btld_pkg::DIGIT_W-1:0] digit,
  input  wire logic                                buffer_end,
  output btld_pkg::result_t                        res
);
  import btld_pkg::*;

  logic                      in_digits;
  logic [COUNT_W-1:0]        digits_left;
  logic [COUNT_W-1:0]        digit_position;
  logic signed [SUM_W-1:0]   running_sum;

  logic signed [DIGIT_W-1:0] sat;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0]        left_dec;

  // Saturate out-of-range digits to the balanced range.
  always_comb begin
    if (digit > DIGIT_HI) begin
      sat = DIGIT_HI;
    end else if (digit < DIGIT_LO) begin
      sat = DIGIT_LO;
    end else begin
      sat = digit;
    end
  end

  assign prod     = PROD_W'(sat) * PROD_W'(pow27(digit_position));
  assign sum_next = running_sum + prod[SUM_W-1:0];
  assign left_dec = digits_left - COUNT_W'(1);

  always_comb begin
    res.emit   = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    if (!in_digits) begin
      if (digit < 5'sd0 || digit > COUNT_MAX) begin
        res.emit   = 1'b1;
        res.status = ST_INVALID;
      end else if (digit == 5'sd0) begin
        res.emit   = 1'b1;
        res.status = ST_OK;
      end else if (buffer_end) begin
        res.emit   = 1'b1;
        res.status = ST_EOF;
      end
    end else begin
      if (left_dec == '0) begin
        res.emit = 1'b1;
        if (sum_next < 0) begin
          res.status = ST_NEGATIVE;
        end else begin
          res.status = ST_OK;
          res.value  = sum_next[VALUE_W-1:0];
        end
      end else if (buffer_end) begin
        res.emit   = 1'b1;
        res.status = ST_EOF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_digits      <= 1'b0;
      digits_left    <= '0;
      digit_position <= '0;
      running_sum    <= '0;
    end else if (step) begin
      if (res.emit) begin
        in_digits      <= 1'b0;
        digits_left    <= '0;
        digit_position <= '0;
        running_sum    <= '0;
      end else if (!in_digits) begin
        in_digits      <= 1'b1;
        digits_left    <= digit[COUNT_W-1:0];
        digit_position <= '0;
        running_sum    <= '0;
      end else begin
        digit_position <= digit_position + COUNT_W'(1);
        digits_left    <= left_dec;
        running_sum    <= sum_next;
      end
    end
  end

  `BTLD_ASSERT_NOW(a_open_field_has_digits, in_digits, digits_left != '0,
    "open field with no digits left")
  `BTLD_ASSERT_NOW(a_field_within_max, in_digits,
    ({1'b0, digit_position} + {1'b0, digits_left}) <= (COUNT_W+1)'(MAX_DIGITS),
    "field runs past the digit limit")

endmodule

`default_nettype wire
